### hw/rtl/tlv_container_block_checker_macros.svh
// assertion macros for the container block checker
`ifndef TLV_CONTAINER_BLOCK_CHECKER_MACROS_SVH
`define TLV_CONTAINER_BLOCK_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is asserted
`define TLVCBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TLVCBC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TLVCBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TLVCBC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### hw/rtl/tlvcbc_pkg.sv
`timescale 1ns / 1ps

package tlvcbc_pkg;

    localparam int LENGTH_BYTES_DEF = 8;
    localparam int HEADER_SIZE      = 20;
    localparam int HOFF_W           = $clog2(HEADER_SIZE + 1);

    // header payload layout: magic, then size, then animation count
    localparam logic [HOFF_W-1:0] HOFF_MAGIC_LAST  = HOFF_W'(3);
    localparam logic [HOFF_W-1:0] HOFF_SIZE_FIRST  = HOFF_W'(4);
    localparam logic [HOFF_W-1:0] HOFF_SIZE_LAST   = HOFF_W'(11);
    localparam logic [HOFF_W-1:0] HOFF_COUNT_FIRST = HOFF_W'(12);
    localparam logic [HOFF_W-1:0] HOFF_COUNT_LAST  = HOFF_W'(HEADER_SIZE - 1);
    localparam logic [HOFF_W-1:0] HOFF_END         = HOFF_W'(HEADER_SIZE);

    localparam logic [7:0]  KIND_HEADER = 8'd1;
    localparam logic [7:0]  KIND_FRAME  = 8'd3;
    localparam logic [63:0] MAGIC_WORD  = 64'h0000_0000_4646_4143;

    localparam int OUT_TDATA_W = 176;

    typedef enum logic [1:0] {
        PH_ID  = 2'd0,
        PH_LEN = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_MAGIC = 3'd1,
        ST_HSIZE = 3'd2,
        ST_COUNT = 3'd3,
        ST_TRUNC = 3'd4
    } status_t;

    typedef struct packed {
        logic        is_final;
        logic [7:0]  block_kind;
        logic [63:0] block_length;
        logic [63:0] anim_total;
        logic [31:0] frames_seen;
        status_t     status_code;
        logic        last_of_run;
    } rec_t;

endpackage

### hw/rtl/tlvcbc_core.sv
`timescale 1ns / 1ps

module tlvcbc_core
    import tlvcbc_pkg::*;
#(
    parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output rec_t       rec_a,
    output rec_t       rec_b,
    output logic [1:0] rec_count
);

    localparam int IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

    phase_t            phase_reg,  phase_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [7:0]        kind_reg,   kind_next;
    logic [63:0]       len_reg,    len_next;
    logic [63:0]       left_reg,   left_next;
    logic [HOFF_W-1:0] hoff_reg,   hoff_next;
    logic [63:0]       hsize_reg,  hsize_next;
    logic [63:0]       acc_reg,    acc_next;
    logic [63:0]       anim_reg,   anim_next;
    logic [31:0]       frames_reg, frames_next;
    status_t           err_reg,    err_next;

    logic    finish;
    status_t fin_status;
    logic [63:0] byte_ext;

    assign byte_ext = {56'd0, data_byte};

    // state update for one byte
    always_comb
    begin
        logic [63:0] acc_v;
        logic [63:0] len_v;
        logic [63:0] base_v;
        logic [2:0]  lane_v;
        status_t     err_v;

        phase_next  = phase_reg;
        idx_next    = idx_reg;
        kind_next   = kind_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        hoff_next   = hoff_reg;
        hsize_next  = hsize_reg;
        acc_next    = acc_reg;
        anim_next   = anim_reg;
        frames_next = frames_reg;
        finish      = 1'b0;
        err_v       = err_reg;
        acc_v       = acc_reg;
        len_v       = len_reg;
        base_v      = acc_reg;
        lane_v      = 3'd0;

        case (phase_reg)
            PH_ID:
            begin
                kind_next  = data_byte;
                len_next   = 64'd0;
                idx_next   = '0;
                hoff_next  = '0;
                hsize_next = 64'd0;
                acc_next   = 64'd0;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                lane_v   = 3'(idx_reg);
                len_v    = len_reg | (byte_ext << {lane_v, 3'b000});
                len_next = len_v;
                if (idx_reg == IDX_W'(LENGTH_BYTES - 1))
                begin
                    idx_next  = '0;
                    left_next = len_v;
                    if (len_v == 64'd0)
                        finish = 1'b1;
                    else
                        phase_next = PH_PAY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                if (kind_reg == KIND_HEADER && hoff_reg < HOFF_END)
                begin
                    hoff_next = hoff_reg + 1'b1;
                    if (hoff_reg < HOFF_SIZE_FIRST)
                    begin
                        // magic bytes share the count accumulator
                        lane_v   = 3'(hoff_reg);
                        acc_v    = acc_reg | (byte_ext << {lane_v, 3'b000});
                        acc_next = acc_v;
                        if (hoff_reg == HOFF_MAGIC_LAST && acc_v != MAGIC_WORD
                            && err_v == ST_OK)
                            err_v = ST_MAGIC;
                    end
                    else if (hoff_reg < HOFF_COUNT_FIRST)
                    begin
                        lane_v     = 3'(hoff_reg - HOFF_SIZE_FIRST);
                        hsize_next = hsize_reg | (byte_ext << {lane_v, 3'b000});
                        if (hoff_reg == HOFF_SIZE_LAST && hsize_next != 64'(HEADER_SIZE)
                            && err_v == ST_OK)
                            err_v = ST_HSIZE;
                    end
                    else
                    begin
                        base_v   = (hoff_reg == HOFF_COUNT_FIRST) ? 64'd0 : acc_reg;
                        lane_v   = 3'(hoff_reg - HOFF_COUNT_FIRST);
                        acc_v    = base_v | (byte_ext << {lane_v, 3'b000});
                        acc_next = acc_v;
                        if (hoff_reg == HOFF_COUNT_LAST)
                            anim_next = acc_v;
                    end
                end
                left_next = left_reg - 64'd1;
                if (left_reg == 64'd1)
                    finish = 1'b1;
            end
        endcase

        if (finish)
        begin
            // short header counts as truncated
            if (kind_reg == KIND_HEADER && hoff_next < HOFF_END && err_v == ST_OK)
                err_v = ST_TRUNC;
            if (kind_reg == KIND_FRAME && frames_reg != '1)
                frames_next = frames_reg + 32'd1;
            phase_next = PH_ID;
        end

        err_next = err_v;

        if (err_v != ST_OK)
            fin_status = err_v;
        else if (phase_next != PH_ID)
            fin_status = ST_TRUNC;
        else if (anim_next != {32'd0, frames_next})
            fin_status = ST_COUNT;
        else
            fin_status = ST_OK;
    end

    // result records for this byte
    always_comb
    begin
        rec_t blk;
        rec_t fin;

        blk.is_final     = 1'b0;
        blk.block_kind   = kind_reg;
        blk.block_length = len_next;
        blk.anim_total   = anim_next;
        blk.frames_seen  = frames_next;
        blk.status_code  = err_next;
        blk.last_of_run  = ~end_of_file;

        fin.is_final     = 1'b1;
        fin.block_kind   = 8'd0;
        fin.block_length = 64'd0;
        fin.anim_total   = anim_next;
        fin.frames_seen  = frames_next;
        fin.status_code  = fin_status;
        fin.last_of_run  = 1'b1;

        if (finish)
        begin
            rec_a     = blk;
            rec_b     = fin;
            rec_count = end_of_file ? 2'd2 : 2'd1;
        end
        else
        begin
            rec_a     = fin;
            rec_b     = fin;
            rec_count = end_of_file ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ID;
            idx_reg    <= '0;
            kind_reg   <= 8'd0;
            len_reg    <= 64'd0;
            left_reg   <= 64'd0;
            hoff_reg   <= '0;
            hsize_reg  <= 64'd0;
            acc_reg    <= 64'd0;
            anim_reg   <= 64'd0;
            frames_reg <= 32'd0;
            err_reg    <= ST_OK;
        end
        else if (fire)
        begin
            if (end_of_file)
            begin
                // end of file: start over for the next file
                phase_reg  <= PH_ID;
                idx_reg    <= '0;
                kind_reg   <= 8'd0;
                len_reg    <= 64'd0;
                left_reg   <= 64'd0;
                hoff_reg   <= '0;
                hsize_reg  <= 64'd0;
                acc_reg    <= 64'd0;
                anim_reg   <= 64'd0;
                frames_reg <= 32'd0;
                err_reg    <= ST_OK;
            end
            else
            begin
                phase_reg  <= phase_next;
                idx_reg    <= idx_next;
                kind_reg   <= kind_next;
                len_reg    <= len_next;
                left_reg   <= left_next;
                hoff_reg   <= hoff_next;
                hsize_reg  <= hsize_next;
                acc_reg    <= acc_next;
                anim_reg   <= anim_next;
                frames_reg <= frames_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

### hw/rtl/tlv_container_block_checker.sv
// path: a byte is registered in the input stage, then its records are registered in the result stage
// throughput: one byte per cycle while the result stream takes each record; a byte that both ends a block
//   and ends the file gives two records, and the input side then waits for the result stage to drain
// reset: rst_n asynchronous, active low; clears parse state, counters and both
//   handshake stages; the next byte is read as a block id
`timescale 1ns / 1ps
`include "tlv_container_block_checker_macros.svh"

module tlv_container_block_checker
    import tlvcbc_pkg::*;
#(
    parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    input  logic                   s_axis_tlast,   // end_of_file
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // block_kind[7:0], block_length[71:8], anim_total[135:72],
    // frames_seen[167:136], status_code[170:168], zero fill[175:171]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,   // is_final
    output logic                   m_axis_tlast    // last_of_run
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;

    // result stage: up to two records, head in slot 0
    rec_t       slot0_reg;
    rec_t       slot1_reg;
    logic [1:0] cnt_reg;

    rec_t       rec_a;
    rec_t       rec_b;
    logic [1:0] rec_count;

    logic pop;
    logic room;
    logic fire;

    assign pop  = m_axis_tvalid && m_axis_tready;
    // the result stage must be empty after this cycle to take a byte's records, as one byte may give two
    assign room = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign fire = in_valid_reg && room;

    assign s_axis_tready = !in_valid_reg || fire;

    // parser state and record build
    tlvcbc_core #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .data_byte   (in_byte_reg),
        .end_of_file (in_eof_reg),
        .rec_a       (rec_a),
        .rec_b       (rec_b),
        .rec_count   (rec_count)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eof_reg  <= s_axis_tlast;
        end
    end

    // result stage count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (fire)
            cnt_reg <= rec_count;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot0_reg <= rec_a;
            slot1_reg <= rec_b;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {5'd0,
                            slot0_reg.status_code,
                            slot0_reg.frames_seen,
                            slot0_reg.anim_total,
                            slot0_reg.block_length,
                            slot0_reg.block_kind};
    assign m_axis_tuser  = slot0_reg.is_final;
    assign m_axis_tlast  = slot0_reg.last_of_run;

    // result stage never holds more than two records
    `TLVCBC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg != 2'd3, "result count overflow")

    // a record that is not the last of its byte is always followed by one more
    `TLVCBC_ASSERT_NXT(a_run_cont, clk, rst_n, pop && !m_axis_tlast, m_axis_tvalid, "lost second record")

    // the end-of-file record always closes the run
    `TLVCBC_ASSERT_IMP(a_final_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "final record not last")

    // the end-of-file record carries no block id or length
    `TLVCBC_ASSERT_IMP(a_final_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, slot0_reg.block_kind == 8'd0 && slot0_reg.block_length == 64'd0, "final record has block fields")

endmodule
